[rtl/buddy_tree_page_allocator_defines.svh]
// assertion macros for the buddy tree page allocator
// expects signals named clk and rst in the scope of each use
`ifndef BUDDY_TREE_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_TREE_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define BTA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define BTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bta_pkg.sv]
// shared constants and types for the buddy tree page allocator
// no dependencies
package bta_pkg;

  localparam int TOTAL_PAGES_DEF = 1024;

  // fixed widths of the channel fields
  localparam int PAGES_W = 11;
  localparam int OFFS_W  = 10;
  localparam int STAT_W  = 2;

  // operation codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTALLOC = 2'd2;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [OFFS_W-1:0]  block_offset;
    logic [PAGES_W-1:0] block_pages;
    logic [PAGES_W-1:0] largest_free;
  } bta_res_t;

endpackage

[rtl/bta_req_if.sv]
// request channel of the buddy tree page allocator
// depends on bta_pkg
interface bta_req_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [bta_pkg::PAGES_W-1:0] request_pages;
  logic [bta_pkg::OFFS_W-1:0]  page_offset;

  modport source (output valid, func, request_pages, page_offset, input ready);
  modport sink (input valid, func, request_pages, page_offset, output ready);
endinterface

[rtl/bta_rsp_if.sv]
// response channel of the buddy tree page allocator
// depends on bta_pkg
interface bta_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bta_pkg::STAT_W-1:0]  status;
  logic [bta_pkg::OFFS_W-1:0]  block_offset;
  logic [bta_pkg::PAGES_W-1:0] block_pages;
  logic [bta_pkg::PAGES_W-1:0] largest_free;

  modport source (output valid, status, block_offset, block_pages, largest_free,
                  input ready);
  modport sink (input valid, status, block_offset, block_pages, largest_free,
                output ready);
endinterface

[rtl/bta_node_ram.sv]
// node store: one write port, one read port, registered read data
// no dependencies
module bta_node_ram #(
  parameter int AW = 10,
  parameter int DW = 22
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/bta_walk.sv]
// tree walker: clearing sweep, allocate descent, free climb, ancestor update
// depends on bta_pkg; drives the node store
module bta_walk #(
  parameter int TOTAL_PAGES = bta_pkg::TOTAL_PAGES_DEF,
  localparam int AW = $clog2(TOTAL_PAGES),
  localparam int VW = AW + 1,
  localparam int PW = 2 * VW
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        func,
  input  logic [bta_pkg::PAGES_W-1:0] request_pages,
  input  logic [bta_pkg::OFFS_W-1:0]  page_offset,
  output logic                        idle,
  output logic                        res_valid,
  input  logic                        res_take,
  output bta_pkg::bta_res_t           res,
  output logic                        ram_wr_en,
  output logic [AW-1:0]               ram_wr_addr,
  output logic [PW-1:0]               ram_wr_data,
  output logic                        ram_rd_en,
  output logic [AW-1:0]               ram_rd_addr,
  input  logic [PW-1:0]               ram_rd_data
);

  localparam int IW = AW + 1;
  localparam int CW = (VW > bta_pkg::PAGES_W) ? VW : bta_pkg::PAGES_W;
  localparam int OW = (AW > bta_pkg::OFFS_W) ? AW : bta_pkg::OFFS_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DOWN  = 3'd2;
  localparam logic [2:0] S_CLIMB = 3'd3;
  localparam logic [2:0] S_UP    = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                  state;
  logic [IW-1:0]               node;
  logic [VW-1:0]               size;
  logic [AW-1:0]               off;
  logic [VW-1:0]               val;
  logic [PW-1:0]               pair;
  logic                        up_first;
  logic                        is_free;
  logic [CW-1:0]               need;
  logic [AW-1:0]               clr_thr;
  logic [VW-1:0]               root;
  logic [bta_pkg::STAT_W-1:0]  res_st;
  logic [AW-1:0]               res_off;
  logic [VW-1:0]               res_pages;

  logic [bta_pkg::PAGES_W-1:0] n_req;
  logic                        page_bad;
  logic [IW-1:0]               leaf;
  logic [VW-1:0]               rd_lo;
  logic [VW-1:0]               rd_hi;
  logic [VW-1:0]               half;
  logic                        fit_l;
  logic                        fit_r;
  logic [IW-1:0]               child;
  logic [VW-1:0]               cur_v;
  logic [PW-1:0]               src;
  logic [PW-1:0]               merged;
  logic [VW-1:0]               par_l;
  logic [VW-1:0]               par_r;
  logic [VW-1:0]               whole;
  logic [VW:0]                 sum;
  logic [VW-1:0]               par_val;
  logic [OW-1:0]               off_ext;
  logic [CW-1:0]               pages_ext;
  logic [CW-1:0]               root_ext;

  // a zero request counts as one page
  assign n_req    = (request_pages == '0) ? bta_pkg::PAGES_W'(1) : request_pages;
  assign page_bad = (OW + 1)'(page_offset) >= (OW + 1)'(TOTAL_PAGES);
  assign leaf     = IW'(OW'(page_offset)) + IW'(TOTAL_PAGES);

  // entry e holds node 2e in the low half and node 2e+1 in the high half
  assign rd_lo = ram_rd_data[VW-1:0];
  assign rd_hi = ram_rd_data[PW-1:VW];
  assign half  = size >> 1;
  assign fit_l = CW'(rd_lo) >= need;
  assign fit_r = CW'(rd_hi) >= need;
  assign child = fit_l ? IW'({node, 1'b0}) : IW'({node, 1'b1});
  assign cur_v = node[0] ? rd_hi : rd_lo;

  // parent value from the freshly updated sibling pair
  assign src     = up_first ? pair : ram_rd_data;
  assign merged  = node[0] ? {val, src[VW-1:0]} : {src[PW-1:VW], val};
  assign par_l   = merged[VW-1:0];
  assign par_r   = merged[PW-1:VW];
  assign whole   = VW'(size << 1);
  assign sum     = {1'b0, par_l} + {1'b0, par_r};
  assign par_val = (is_free && sum == {1'b0, whole}) ? whole :
                   ((par_l > par_r) ? par_l : par_r);

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = off;
    ram_wr_data = {size, size};
    ram_rd_en   = 1'b0;
    ram_rd_addr = AW'(node >> 2);
    unique case (state)
      S_CLEAR: begin
        ram_wr_en = 1'b1;
      end
      S_IDLE: begin
        if (start) begin
          if (func == bta_pkg::FUNC_ALLOC) begin
            ram_rd_en   = CW'(n_req) <= CW'(root);
            ram_rd_addr = AW'(1);
          end else begin
            ram_rd_en   = !page_bad;
            ram_rd_addr = AW'(leaf >> 1);
          end
        end
      end
      S_DOWN: begin
        ram_rd_en   = (fit_l || fit_r) && (half != VW'(1));
        ram_rd_addr = AW'(child);
      end
      S_CLIMB: begin
        ram_rd_en = (cur_v != '0) && (node != IW'(1));
      end
      S_UP: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = AW'(node >> 1);
        ram_wr_data = merged;
        ram_rd_en   = node != IW'(1);
      end
      S_DONE: begin
        ram_rd_en = 1'b0;
      end
      default: begin
        ram_rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      off      <= AW'(TOTAL_PAGES - 1);
      size     <= VW'(1);
      clr_thr  <= AW'(TOTAL_PAGES / 2);
      root     <= VW'(TOTAL_PAGES);
      up_first <= 1'b0;
      is_free  <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          // sweep from the leaves upward, doubling at each level boundary
          if (off == clr_thr) begin
            size    <= size << 1;
            clr_thr <= clr_thr >> 1;
          end
          if (off == '0) begin
            state <= S_IDLE;
          end else begin
            off <= off - AW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            if (func == bta_pkg::FUNC_ALLOC) begin
              if (CW'(n_req) > CW'(root)) begin
                res_st    <= bta_pkg::ST_NOSPACE;
                res_off   <= '0;
                res_pages <= '0;
                state     <= S_DONE;
              end else begin
                node    <= IW'(1);
                size    <= VW'(TOTAL_PAGES);
                off     <= '0;
                pair    <= {root, VW'(0)};
                need    <= CW'(n_req);
                is_free <= 1'b0;
                state   <= S_DOWN;
              end
            end else begin
              if (page_bad) begin
                res_st    <= bta_pkg::ST_NOTALLOC;
                res_off   <= '0;
                res_pages <= '0;
                state     <= S_DONE;
              end else begin
                node    <= leaf;
                size    <= VW'(1);
                off     <= AW'(page_offset);
                is_free <= 1'b1;
                state   <= S_CLIMB;
              end
            end
          end
        end
        S_DOWN: begin
          up_first <= 1'b1;
          val      <= '0;
          if (fit_l || fit_r) begin
            node <= child;
            size <= half;
            pair <= ram_rd_data;
            if (half == VW'(1)) begin
              res_pages <= half;
              res_off   <= fit_l ? off : off + AW'(half);
              state     <= S_UP;
            end
            if (!fit_l) begin
              off <= off + AW'(half);
            end
          end else begin
            res_pages <= size;
            res_off   <= off;
            state     <= S_UP;
          end
        end
        S_CLIMB: begin
          if (cur_v != '0) begin
            if (node == IW'(1)) begin
              res_st    <= bta_pkg::ST_NOTALLOC;
              res_off   <= '0;
              res_pages <= '0;
              state     <= S_DONE;
            end else begin
              node <= node >> 1;
              size <= size << 1;
              off  <= off & ~AW'(size);
            end
          end else begin
            // first used node on the path owns the whole block
            pair      <= ram_rd_data;
            val       <= size;
            up_first  <= 1'b1;
            res_pages <= size;
            res_off   <= off;
            state     <= S_UP;
          end
        end
        S_UP: begin
          up_first <= 1'b0;
          if (node == IW'(1)) begin
            root   <= val;
            res_st <= bta_pkg::ST_OK;
            state  <= S_DONE;
          end else begin
            val  <= par_val;
            node <= node >> 1;
            size <= size << 1;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign idle      = state == S_IDLE;
  assign res_valid = state == S_DONE;

  assign off_ext   = OW'(res_off);
  assign pages_ext = CW'(res_pages);
  assign root_ext  = CW'(root);

  assign res.status       = res_st;
  assign res.block_offset = off_ext[bta_pkg::OFFS_W-1:0];
  assign res.block_pages  = pages_ext[bta_pkg::PAGES_W-1:0];
  assign res.largest_free = root_ext[bta_pkg::PAGES_W-1:0];

endmodule

[rtl/buddy_tree_page_allocator.sv]
// Buddy tree page allocator, top level.
// Channels: req (sink) carries func, request_pages and page_offset; rsp (source)
// carries status, block_offset, block_pages and largest_free, one per request.
// A transaction takes place when valid and ready are both high at a clock edge.
// The node tree lives in one memory of TOTAL_PAGES entries, each holding a pair
// of sibling nodes, with one read and one write port and registered read data.
// An allocate walks down one level per cycle and then rewrites one ancestor
// per cycle; a free climbs one level per cycle and then rewrites the same way.
// A no-space or out-of-range request skips the walk and goes straight to its result.
// One request is in work at a time; req.ready is high only while the walker
// is idle, and the walker can take the next request while rsp still waits.
// After reset the memory is swept to the all-free tree, one entry per cycle;
// req.ready stays low during the sweep.
// A stalled rsp holds its result; a further result waits inside the walker.
// depends on bta_pkg, bta_req_if, bta_rsp_if, bta_node_ram, bta_walk

`include "buddy_tree_page_allocator_defines.svh"

module buddy_tree_page_allocator #(
  parameter int TOTAL_PAGES = bta_pkg::TOTAL_PAGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bta_req_if.sink    req,
  bta_rsp_if.source  rsp
);

  localparam int AW = $clog2(TOTAL_PAGES);
  localparam int PW = 2 * (AW + 1);

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [PW-1:0]     ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [PW-1:0]     ram_rd_data;

  logic              idle;
  logic              res_valid;
  logic              res_take;
  bta_pkg::bta_res_t res;

  logic              out_valid;
  bta_pkg::bta_res_t out_res;

  bta_node_ram #(
    .AW (AW),
    .DW (PW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  bta_walk #(
    .TOTAL_PAGES (TOTAL_PAGES)
  ) u_walk (
    .clk           (clk),
    .rst           (rst),
    .start         (req.valid && idle),
    .func          (req.func),
    .request_pages (req.request_pages),
    .page_offset   (req.page_offset),
    .idle          (idle),
    .res_valid     (res_valid),
    .res_take      (res_take),
    .res           (res),
    .ram_wr_en     (ram_wr_en),
    .ram_wr_addr   (ram_wr_addr),
    .ram_wr_data   (ram_wr_data),
    .ram_rd_en     (ram_rd_en),
    .ram_rd_addr   (ram_rd_addr),
    .ram_rd_data   (ram_rd_data)
  );

  assign req.ready = idle;

  // result register between the walker and the response channel
  assign res_take = res_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res_take) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_res.status;
  assign rsp.block_offset = out_res.block_offset;
  assign rsp.block_pages  = out_res.block_pages;
  assign rsp.largest_free = out_res.largest_free;

  `BTA_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "walker still idle after accepting a request")
  `BTA_ASSERT_NOW(a_idle_no_result, req.ready, !res_valid, "walker idle with a result pending")
  `BTA_ASSERT_NOW(a_fail_fields_zero, rsp.valid && rsp.status != bta_pkg::ST_OK, rsp.block_offset == '0 && rsp.block_pages == '0, "failed request reports a block")

endmodule
